// ===== src/chkv_pkg.sv =====
// Shared types and constants for the chained hash key-value table.
// Holds field widths, opcode and status codes, and the controller/datapath structs.
// No dependencies.
package chkv_pkg;

  localparam int KEY_W  = 31;
  localparam int ITEM_W = 32;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;
  localparam int CFG_W  = 7;
  localparam int BIT_W  = $clog2(KEY_W);

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_MISS = 2'd2;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_ADD,
    WR_COPY,
    WR_INVAL
  } wr_kind_t;

  typedef enum logic [1:0] {
    RES_OK,
    RES_FULL,
    RES_MISS,
    RES_HIT
  } res_kind_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [ITEM_W-1:0] item;
  } slot_t;

  typedef struct packed {
    logic      load;
    logic      clr_step;
    logic      div_step;
    logic      slot_inc;
    logic      addr_next;
    wr_kind_t  wr;
    logic      set_res;
    res_kind_t res;
    logic      load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic            clr_last;
    logic            div_last;
    logic            hit;
    logic            empty;
    logic            slot_last;
    logic            slot_pen;
    logic            out_free;
    logic [OP_W-1:0] op;
  } dp_stat_t;

endpackage

// ===== src/chkv_dp.sv =====
// Datapath of the chained hash key-value table: slot memory, bit-serial modulo,
// slot counter, compare and result/output registers. Depends on chkv_pkg.
module chkv_dp #(
  parameter int NUM_BUCKETS  = 64,
  parameter int BUCKET_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  chkv_pkg::dp_cmd_t              cmd,
  output chkv_pkg::dp_stat_t             stat,
  input  logic [chkv_pkg::OP_W-1:0]      in_opcode,
  input  logic [chkv_pkg::KEY_W-1:0]     in_key,
  input  logic [chkv_pkg::ITEM_W-1:0]    in_item,
  input  logic                           cfg_valid,
  input  logic [chkv_pkg::CFG_W-1:0]     cfg_bucket_count,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [chkv_pkg::ST_W-1:0]      out_status,
  output logic                           out_found,
  output logic [chkv_pkg::ITEM_W-1:0]    out_item_out
);
  import chkv_pkg::*;

  localparam int SLOTS = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MW    = $clog2(NUM_BUCKETS + 1);
  localparam int SW    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;

  slot_t mem [SLOTS];

  logic [CFG_W-1:0]  cfg_r;
  logic [AW-1:0]     clr_cnt_r;
  logic [OP_W-1:0]   op_r;
  logic [KEY_W-1:0]  key_r;
  logic [KEY_W-1:0]  key_sh_r;
  logic [ITEM_W-1:0] item_r;
  logic [MW-1:0]     rem_r;
  logic [MW-1:0]     rem_nxt;
  logic [BIT_W-1:0]  bit_cnt_r;
  logic [SW-1:0]     slot_r;
  slot_t             rd_r;
  logic [ST_W-1:0]   res_status_r;
  logic              res_found_r;
  logic [ITEM_W-1:0] res_item_r;
  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic              out_found_r;
  logic [ITEM_W-1:0] out_item_r;

  logic [MW-1:0]     mod_eff;
  logic [MW:0]       trial;
  logic [AW-1:0]     base;
  logic [AW-1:0]     addr;
  logic              wr_en;
  slot_t             wr_data;

  // Zero or an oversized count falls back to the full bucket count.
  always_comb begin
    if (cfg_r == '0 || 32'(cfg_r) > 32'(NUM_BUCKETS)) begin
      mod_eff = MW'(NUM_BUCKETS);
    end else begin
      mod_eff = MW'(cfg_r);
    end
  end

  // Restoring remainder, one key bit per cycle, MSB first.
  always_comb begin
    trial = {rem_r, key_sh_r[KEY_W-1]};
    if (trial >= {1'b0, mod_eff}) begin
      rem_nxt = MW'(trial - {1'b0, mod_eff});
    end else begin
      rem_nxt = MW'(trial);
    end
  end

  assign base = AW'(rem_r) * AW'(BUCKET_DEPTH);

  always_comb begin
    if (cmd.wr == WR_CLEAR) begin
      addr = clr_cnt_r;
    end else begin
      addr = base + AW'(slot_r) + AW'(cmd.addr_next);
    end
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_data = '{valid: 1'b0, key: key_r, item: item_r};
    case (cmd.wr)
      WR_CLEAR: wr_data.valid = 1'b0;
      WR_ADD:   wr_data.valid = 1'b1;
      WR_COPY:  wr_data = rd_r;
      WR_INVAL: wr_data.valid = 1'b0;
      default:  wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    rd_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cfg_r <= cfg_bucket_count;
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_opcode;
      key_r     <= in_key;
      key_sh_r  <= in_key;
      item_r    <= in_item;
      rem_r     <= '0;
      bit_cnt_r <= '0;
      slot_r    <= '0;
    end else begin
      if (cmd.div_step) begin
        rem_r     <= rem_nxt;
        key_sh_r  <= key_sh_r << 1;
        bit_cnt_r <= bit_cnt_r + BIT_W'(1);
      end
      if (cmd.slot_inc) begin
        slot_r <= slot_r + SW'(1);
      end
    end
    if (cmd.set_res) begin
      case (cmd.res)
        RES_OK: begin
          res_status_r <= ST_OK;
          res_found_r  <= 1'b0;
          res_item_r   <= '0;
        end
        RES_FULL: begin
          res_status_r <= ST_FULL;
          res_found_r  <= 1'b0;
          res_item_r   <= '0;
        end
        RES_MISS: begin
          res_status_r <= ST_MISS;
          res_found_r  <= 1'b0;
          res_item_r   <= '0;
        end
        RES_HIT: begin
          res_status_r <= ST_OK;
          res_found_r  <= 1'b1;
          res_item_r   <= rd_r.item;
        end
        default: begin
          res_status_r <= ST_OK;
          res_found_r  <= 1'b0;
          res_item_r   <= '0;
        end
      endcase
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_item_r   <= res_item_r;
    end
  end

  assign stat.clr_last  = (clr_cnt_r == AW'(SLOTS - 1));
  assign stat.div_last  = (bit_cnt_r == BIT_W'(KEY_W - 1));
  assign stat.hit       = rd_r.valid && (rd_r.key == key_r);
  assign stat.empty     = !rd_r.valid;
  assign stat.slot_last = (slot_r == SW'(BUCKET_DEPTH - 1));
  assign stat.slot_pen  = (slot_r == SW'(BUCKET_DEPTH - 2));
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.op        = op_r;

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_found    = out_found_r;
  assign out_item_out = out_item_r;

endmodule

// ===== src/chkv_ctrl.sv =====
// Controller of the chained hash key-value table: sequences clearing, modulo,
// bucket scan, remove shift and result handoff. Depends on chkv_pkg.
module chkv_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  chkv_pkg::dp_stat_t stat,
  output chkv_pkg::dp_cmd_t  cmd
);
  import chkv_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_TAIL,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.wr       = WR_CLEAR;
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: begin
        case (stat.op)
          OP_ADD: begin
            if (stat.empty) begin
              cmd.wr      = WR_ADD;
              cmd.set_res = 1'b1;
              cmd.res     = RES_OK;
              state_nxt   = S_DONE;
            end else if (stat.slot_last) begin
              cmd.set_res = 1'b1;
              cmd.res     = RES_FULL;
              state_nxt   = S_DONE;
            end else begin
              cmd.slot_inc = 1'b1;
              state_nxt    = S_SCAN_RD;
            end
          end
          OP_REMOVE: begin
            if (stat.hit) begin
              state_nxt = stat.slot_last ? S_TAIL : S_SHIFT_RD;
            end else if (stat.slot_last) begin
              cmd.set_res = 1'b1;
              cmd.res     = RES_MISS;
              state_nxt   = S_DONE;
            end else begin
              cmd.slot_inc = 1'b1;
              state_nxt    = S_SCAN_RD;
            end
          end
          OP_LOOKUP: begin
            if (stat.hit) begin
              cmd.set_res = 1'b1;
              cmd.res     = RES_HIT;
              state_nxt   = S_DONE;
            end else if (stat.slot_last) begin
              cmd.set_res = 1'b1;
              cmd.res     = RES_MISS;
              state_nxt   = S_DONE;
            end else begin
              cmd.slot_inc = 1'b1;
              state_nxt    = S_SCAN_RD;
            end
          end
          default: begin
            cmd.set_res = 1'b1;
            cmd.res     = RES_OK;
            state_nxt   = S_DONE;
          end
        endcase
      end
      // Pull the younger neighbor down one slot to close the gap.
      S_SHIFT_RD: begin
        cmd.addr_next = 1'b1;
        state_nxt     = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.wr       = WR_COPY;
        cmd.slot_inc = 1'b1;
        state_nxt    = stat.slot_pen ? S_TAIL : S_SHIFT_RD;
      end
      S_TAIL: begin
        cmd.wr      = WR_INVAL;
        cmd.set_res = 1'b1;
        cmd.res     = RES_OK;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register can take the word.
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLEAR) |=> (state_r != S_CLEAR))
    else $error("clearing pass re-entered outside reset");

  a_add_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr == WR_ADD) |-> (stat.empty && stat.op == OP_ADD))
    else $error("add wrote over an occupied slot");

  a_hit_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.set_res && cmd.res == RES_HIT) |-> stat.hit)
    else $error("lookup reported a hit without a key match");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("result loaded over an unaccepted word");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_DIV))
    else $error("accepted word did not start the modulo");

endmodule

// ===== src/chained_hash_key_value_table_top.sv =====
// From accept to out_valid a word passes the 31-step bit-serial modulo, then a read state and a
// check state per slot scanned (add/lookup: k slots, 1..BUCKET_DEPTH); remove walks the whole bucket,
// moving younger entries down one slot after a match. The slot memory is single-port.
// One word in flight; the next can be taken the cycle after its result enters the output register.
// Reset: a clearing pass marks all NUM_BUCKETS*BUCKET_DEPTH slots empty, with in_ready low;
// configuration writes are taken throughout. Depends on chkv_pkg, chkv_ctrl and chkv_dp.
module chained_hash_key_value_table_top #(
  parameter int NUM_BUCKETS  = 64,
  parameter int BUCKET_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [chkv_pkg::OP_W-1:0]   in_opcode,
  input  logic [chkv_pkg::KEY_W-1:0]  in_key,
  input  logic [chkv_pkg::ITEM_W-1:0] in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [chkv_pkg::ST_W-1:0]   out_status,
  output logic                        out_found,
  output logic [chkv_pkg::ITEM_W-1:0] out_item_out,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [chkv_pkg::CFG_W-1:0]  cfg_bucket_count
);
  import chkv_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  chkv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  chkv_dp #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_opcode),
    .in_key           (in_key),
    .in_item          (in_item),
    .cfg_valid        (cfg_valid),
    .cfg_bucket_count (cfg_bucket_count),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_item_out     (out_item_out)
  );

endmodule

// ===== tb/sv/chained_hash_key_value_table_top_test.sv =====
`timescale 1ns / 1ps
// Testbench for chained_hash_key_value_table_top: directed and random add/remove/lookup
// traffic under several bucket counts, checked against a shadow copy of the slot store.
// Depends on chkv_pkg and the top level.
module chained_hash_key_value_table_top_test;
  import chkv_pkg::*;

  localparam int NUM_BUCKETS  = 64;
  localparam int BUCKET_DEPTH = 4;
  localparam int SLOT_TOTAL   = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 60;
  localparam int PHASE_WORDS  = 134;
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  typedef struct {
    logic [ST_W-1:0]   status;
    logic              found;
    logic [ITEM_W-1:0] item_out;
  } reply_t;

  // Shadow of the slot store; predicts one reply per accepted request.
  class kv_shadow;
    bit              used[SLOT_TOTAL];
    bit [KEY_W-1:0]  keys[SLOT_TOTAL];
    bit [ITEM_W-1:0] words[SLOT_TOTAL];
    bit [CFG_W-1:0]  bucket_count;
    reply_t          replies_due[$];
    int errors, checked, stored, full_adds, hits, misses;

    function void set_bucket_count(bit [CFG_W-1:0] v);
      bucket_count = v;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function int unsigned base_of(bit [KEY_W-1:0] key);
      int unsigned m;
      m = bucket_count;
      if (m == 0 || m > NUM_BUCKETS) m = NUM_BUCKETS;
      return (key % m) * BUCKET_DEPTH;
    endfunction

    function int oldest_match(int unsigned base, bit [KEY_W-1:0] key);
      for (int d = 0; d < BUCKET_DEPTH; d++)
        if (used[base + d] && keys[base + d] == key) return d;
      return BUCKET_DEPTH;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                               logic [ITEM_W-1:0] data);
      reply_t      r;
      int unsigned base;
      int          d;
      r.status   = ST_OK;
      r.found    = 1'b0;
      r.item_out = '0;
      base       = base_of(key);
      case (op)
        OP_ADD: begin
          r.status = ST_FULL;
          for (d = 0; d < BUCKET_DEPTH; d++) begin
            if (!used[base + d]) begin
              used[base + d]  = 1'b1;
              keys[base + d]  = key;
              words[base + d] = data;
              r.status        = ST_OK;
              break;
            end
          end
          if (r.status == ST_FULL) full_adds++;
          else stored++;
        end
        OP_REMOVE: begin
          d = oldest_match(base, key);
          if (d == BUCKET_DEPTH) begin
            r.status = ST_MISS;
            misses++;
          end else begin
            // close the gap: younger entries move down one slot
            for (; d < BUCKET_DEPTH - 1; d++) begin
              used[base + d]  = used[base + d + 1];
              keys[base + d]  = keys[base + d + 1];
              words[base + d] = words[base + d + 1];
            end
            used[base + BUCKET_DEPTH - 1] = 1'b0;
          end
        end
        OP_LOOKUP: begin
          d = oldest_match(base, key);
          if (d == BUCKET_DEPTH) begin
            r.status = ST_MISS;
            misses++;
          end else begin
            r.found    = 1'b1;
            r.item_out = words[base + d];
            hits++;
          end
        end
        default: ;
      endcase
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [ST_W-1:0] status, logic found,
                              logic [ITEM_W-1:0] item_out);
      reply_t want;
      checked++;
      if (replies_due.size() == 0) begin
        $error("reply with nothing pending: status %0d found %0d item_out %h",
               status, found, item_out);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, found);
        errors++;
      end
      if (item_out !== want.item_out) begin
        $error("item_out: expected %h, got %h", want.item_out, item_out);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_opcode = '0;
  logic [KEY_W-1:0]  in_key = '0;
  logic [ITEM_W-1:0] in_item = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [ST_W-1:0]   out_status;
  logic              out_found;
  logic [ITEM_W-1:0] out_item_out;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_bucket_count = '0;

  kv_shadow shadow = new();
  bit       no_idle = 1'b0;
  bit       hold_req = 1'b0;
  int       cycles = 0;
  int       settings_used = 0;

  chained_hash_key_value_table_top #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_key           (in_key),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_item_out     (out_item_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_bucket_count (cfg_bucket_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycles, shadow.pending());
      $display("chained_hash_key_value_table_top: mismatch");
      $finish;
    end
  end

  // Reply side: random stalls, quiet stretches, and one long hold-off on request.
  initial begin
    int stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      shadow.check_reply(out_status, out_found, out_item_out);
      @(negedge clk);
    end
  end

  // Offer one request word; valid stays up across back-to-back words.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic [ITEM_W-1:0] data);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_opcode = op;
    in_key    = key;
    in_item   = data;
    do @(posedge clk); while (!in_ready);
    shadow.note_request(op, key, data);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted reply has come back.
  task automatic drain();
    in_valid = 1'b0;
    while (shadow.pending() != 0) @(negedge clk);
  endtask

  task automatic write_bucket_count(input logic [CFG_W-1:0] v);
    cfg_valid        = 1'b1;
    cfg_bucket_count = v;
    do @(posedge clk); while (!cfg_ready);
    shadow.set_bucket_count(v);
    settings_used++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random traffic over a small key pool so buckets collide, fill and empty again.
  task automatic random_phase(input logic [CFG_W-1:0] v, input int count, input bit with_hold);
    logic [KEY_W-1:0]  pool[10];
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;
    int                issued;
    int                r;
    drain();
    write_bucket_count(v);
    foreach (pool[i]) pool[i] = KEY_W'(($urandom << 6) | $urandom_range(0, 3));
    issued = 0;
    while (issued < count) begin
      if (issued % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (with_hold && issued == 30) hold_req = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 40) op = OP_ADD;
      else if (r < 68) op = OP_REMOVE;
      else if (r < 97) op = OP_LOOKUP;
      else op = OP_NOP;
      if ($urandom_range(0, 99) < 85) key = pool[$urandom_range(0, 9)];
      else key = KEY_W'($urandom);
      send_request(op, key, $urandom);
      if (op != OP_NOP) issued++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    // taken during the clearing pass as well
    write_bucket_count('0);

    // Directed: empty bucket, duplicates, full bucket, oldest-first remove and lookup.
    send_request(OP_LOOKUP, '0, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 31'h7FFF_FFFF, '0);
    send_request(OP_ADD, '0, '0);
    send_request(OP_ADD, 31'd64, 32'hFFFF_FFFF);
    send_request(OP_ADD, '0, 32'hA5A5_A5A5);
    send_request(OP_ADD, 31'd128, 32'h5A5A_5A5A);
    send_request(OP_ADD, 31'd192, 32'h0000_0001);
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_LOOKUP, 31'd64, '0);
    send_request(OP_REMOVE, '0, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_LOOKUP, 31'd192, '0);
    send_request(OP_REMOVE, 31'd64, '0);
    send_request(OP_ADD, 31'd192, 32'h8000_0000);
    send_request(OP_LOOKUP, 31'd192, '0);
    send_request(OP_ADD, 31'h7FFF_FFFF, 32'h1234_5678);
    send_request(OP_LOOKUP, 31'h7FFF_FFFF, '0);
    send_request(OP_NOP, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_REMOVE, 31'h7FFF_FFFF, '0);
    send_request(OP_REMOVE, 31'h7FFF_FFFF, '0);
    send_request(OP_LOOKUP, 31'h7FFF_FFFF, '0);

    // entries stay put across bucket-count changes
    random_phase(7'd1, PHASE_WORDS, 1'b0);
    random_phase(7'd64, PHASE_WORDS, 1'b1);
    random_phase(7'd127, PHASE_WORDS, 1'b0);
    random_phase(7'd5, PHASE_WORDS, 1'b0);
    random_phase(7'd0, PHASE_WORDS, 1'b0);
    random_phase(CFG_W'($urandom_range(2, 63)), PHASE_WORDS, 1'b0);

    drain();
    repeat (SETTLE) @(negedge clk);
    $display("covered %0d replies over %0d bucket-count settings", shadow.checked,
             settings_used);
    $display("adds stored %0d, bucket full %0d, lookup hits %0d, misses %0d",
             shadow.stored, shadow.full_adds, shadow.hits, shadow.misses);
    if (shadow.errors == 0) begin
      $display("chained_hash_key_value_table_top: match");
    end else begin
      $display("chained_hash_key_value_table_top: mismatch");
    end
    $finish;
  end

endmodule
